// ----- sv/sojb_pkg.sv -----
// Shared types and codes for the sequence-ordered jitter buffer.
package sojb_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RESP
  } sojb_state_t;

  localparam logic [2:0] STAT_NEW_HEAD = 3'd0;
  localparam logic [2:0] STAT_FILLED   = 3'd1;
  localparam logic [2:0] STAT_REPLACED = 3'd2;
  localparam logic [2:0] STAT_DROPPED  = 3'd3;
  localparam logic [2:0] STAT_READ     = 3'd4;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

endpackage

// ----- sv/seq_ordered_jitter_buffer.sv -----
// Top level of the sequence-ordered jitter buffer: window control, slot RAM and output register.
//
//   Channel  Dir  Signals                       Contents
//   s_*      in   s_tvalid s_tready s_tdata     op in tuser, seq/payload/offset in tdata
//   m_*      out  m_tvalid m_tready m_tdata     status in tuser, head/occupancy/slot in tdata
//   cfg_*    in   cfg_we cfg_wdata              window_limit register
//
// In each transaction the accept cycle updates the window and issues the slot RAM access,
// and the response state then loads the registered RAM data into the output register.
// Synchronous reset empties the window at once through the per-slot valid flops.
// A stalled output holds the block in its response cycle; a new transaction is taken
// while the previous result still waits, as long as the response has been loaded.
module seq_ordered_jitter_buffer
  import sojb_pkg::*;
#(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 32,
  localparam int IN_TW        = ((20 + PAYLOAD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW       = ((22 + PAYLOAD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,   // seq_number[15:0], payload, slot_offset[3:0]
  input  logic [0:0]        s_tuser,   // op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata,   // head_seq[15:0], occupancy[4:0], slot_full, slot_payload
  output logic [2:0]        m_tuser,   // status
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = AW + 5;

  sojb_state_t state, state_next;

  logic [4:0]               window_limit;
  logic [15:0]              head_seq;
  logic [LW-1:0]            len;
  logic [AW-1:0]            hp;
  logic [DEPTH-1:0]         vld;

  logic [15:0]              head_seq_next;
  logic [LW-1:0]            len_next;
  logic [AW-1:0]            hp_next;
  logic [DEPTH-1:0]         vld_next;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [PAYLOAD_WIDTH-1:0] ram_rdata;
  logic [2:0]               status_now;
  logic                     full_now;

  logic [2:0]               p_status;
  logic [15:0]              p_head;
  logic [LW-1:0]            p_len;
  logic                     p_full;

  logic                     in_acc;
  logic                     out_free;
  logic                     op_in;
  logic [15:0]              seq_in;
  logic [PAYLOAD_WIDTH-1:0] pay_in;
  logic [3:0]               off_in;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign op_in    = s_tuser[0];
  assign seq_in   = s_tdata[15:0];
  assign pay_in   = s_tdata[16 +: PAYLOAD_WIDTH];
  assign off_in   = s_tdata[16 + PAYLOAD_WIDTH +: 4];

  function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] h, input logic [PW-1:0] o);
    logic [PW-1:0] s;
    s = PW'(h) + PW'(DEPTH) - o;
    if (s >= PW'(DEPTH)) begin
      s = s - PW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    logic [15:0]   fwd;
    logic [15:0]   back;
    logic [16:0]   fwd17;
    logic [16:0]   len17;
    logic [16:0]   lim;
    logic [16:0]   len_tmp;
    logic [PW-1:0] adv;
    logic [PW-1:0] span;
    logic [PW-1:0] iv;
    logic [AW-1:0] phys;
    fwd   = seq_in - head_seq;
    back  = head_seq - seq_in;
    fwd17 = 17'(fwd);
    len17 = 17'(len);
    if (window_limit == 5'd0) begin
      lim = 17'd1;
    end else if (17'(window_limit) > 17'(DEPTH)) begin
      lim = 17'(DEPTH);
    end else begin
      lim = 17'(window_limit);
    end
    len_tmp       = len17;
    adv           = '0;
    span          = '0;
    iv            = '0;
    phys          = slot_addr(hp, PW'(off_in));
    head_seq_next = head_seq;
    hp_next       = hp;
    vld_next      = vld;
    ram_we        = 1'b0;
    ram_waddr     = hp;
    ram_re        = 1'b0;
    ram_raddr     = phys;
    status_now    = STAT_READ;
    full_now      = 1'b0;
    if (op_in) begin
      full_now  = (17'(off_in) < len17) && vld[phys];
      ram_re    = in_acc && full_now;
    end else begin
      if (len == '0) begin
        head_seq_next = seq_in;
        len_tmp       = 17'd1;
        vld_next[hp]  = 1'b1;
        ram_we        = in_acc;
        status_now    = STAT_NEW_HEAD;
      end else if (fwd != 16'd0 && !fwd[15]) begin
        head_seq_next = seq_in;
        len_tmp       = len17 + fwd17;
        if (len_tmp > 17'(DEPTH)) begin
          len_tmp = 17'(DEPTH);
        end
        if (fwd17 >= 17'(DEPTH)) begin
          vld_next = '0;
        end else begin
          adv = PW'(hp) + PW'(fwd[AW-1:0]);
          if (adv >= PW'(DEPTH)) begin
            adv = adv - PW'(DEPTH);
          end
          hp_next = adv[AW-1:0];
          for (int i = 0; i < DEPTH; i++) begin
            iv = PW'(i);
            if (iv >= PW'(hp)) begin
              span = iv - PW'(hp);
            end else begin
              span = iv + PW'(DEPTH) - PW'(hp);
            end
            if (span != '0 && 17'(span) < fwd17) begin
              vld_next[i] = 1'b0;
            end
          end
        end
        vld_next[hp_next] = 1'b1;
        ram_we            = in_acc;
        ram_waddr         = hp_next;
        status_now        = STAT_NEW_HEAD;
      end else if (17'(back) < len17) begin
        phys           = slot_addr(hp, back[PW-1:0]);
        status_now     = vld[phys] ? STAT_REPLACED : STAT_FILLED;
        vld_next[phys] = 1'b1;
        ram_we         = in_acc;
        ram_waddr      = phys;
      end else begin
        status_now = STAT_DROPPED;
      end
      if (len_tmp > lim) begin
        len_tmp = lim;
      end
    end
    len_next = len_tmp[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= LIMIT_RESET;
      head_seq     <= '0;
      len          <= '0;
      hp           <= '0;
      vld          <= '0;
    end else begin
      if (cfg_we) begin
        window_limit <= cfg_wdata;
      end
      if (in_acc) begin
        head_seq <= head_seq_next;
        len      <= len_next;
        hp       <= hp_next;
        vld      <= vld_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_status <= status_now;
      p_head   <= head_seq_next;
      p_len    <= op_in ? len : len_next;
      p_full   <= full_now;
    end
  end

  sojb_ram #(
    .WIDTH(PAYLOAD_WIDTH),
    .DEPTH(DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(pay_in),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic [15:0]              len_ext;
  logic [PAYLOAD_WIDTH-1:0] out_pay;

  assign len_ext = 16'(p_len);
  assign out_pay = p_full ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      m_tuser <= p_status;
      m_tdata <= OUT_TW'({out_pay, p_full, len_ext[4:0], p_head});
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    17'(len) <= 17'(DEPTH))
    else $error("window length exceeds the slot count");

  a_accept_to_resp: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_RESP) && !s_tready)
    else $error("accepted transaction did not enter the response cycle");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) && m_tvalid && !m_tready |=> (state == ST_RESP))
    else $error("response left while the output register was still occupied");

  a_delivery_nonempty: assert property (@(posedge clk) disable iff (rst)
    in_acc && !op_in |=> len != '0)
    else $error("window empty after a delivered packet");

endmodule

// ----- sv/sojb_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module sojb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the sequence-ordered jitter buffer.
module tb;
  import sojb_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic OP_DELIVER = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef struct {
    logic        op;
    logic [15:0] seq;
    logic [31:0] payload;
    logic [3:0]  offset;
  } packet_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] head;
    logic [4:0]  occ;
    logic        full;
    logic [31:0] payload;
  } window_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  packet_t        pending_packets[$];
  window_result_t expected_results[$];

  logic [15:0] win_head = '0;
  int          win_len = 0;
  logic        win_valid[DEPTH];
  logic [31:0] win_data[DEPTH];
  logic [4:0]  win_limit = LIMIT_RESET;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   sent_at_edge = 1'b0;
  int   error_count = 0;
  int   cycle_count = 0;
  logic [15:0] gen_head = '0;

  seq_ordered_jitter_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic window_result_t jitter_step(packet_t p);
    window_result_t r;
    logic [15:0] fwd;
    logic [15:0] back;
    int lim;
    r.status = STAT_READ;
    r.full = 1'b0;
    r.payload = '0;
    if (p.op == OP_READ) begin
      if (int'(p.offset) < win_len && win_valid[p.offset]) begin
        r.full = 1'b1;
        r.payload = win_data[p.offset];
      end
    end else begin
      fwd = p.seq - win_head;
      back = win_head - p.seq;
      if (win_len == 0) begin
        win_head = p.seq;
        win_len = 1;
        win_valid[0] = 1'b1;
        win_data[0] = p.payload;
        r.status = STAT_NEW_HEAD;
      end else if (fwd >= 16'd1 && fwd <= 16'd32767) begin
        for (int k = DEPTH - 1; k >= 0; k--) begin
          if (k >= int'(fwd) && (k - int'(fwd)) < win_len) begin
            win_valid[k] = win_valid[k - int'(fwd)];
            win_data[k] = win_data[k - int'(fwd)];
          end else begin
            win_valid[k] = 1'b0;
            win_data[k] = '0;
          end
        end
        win_valid[0] = 1'b1;
        win_data[0] = p.payload;
        win_head = p.seq;
        win_len = win_len + int'(fwd);
        if (win_len > DEPTH) win_len = DEPTH;
        r.status = STAT_NEW_HEAD;
      end else if (int'(back) < win_len && int'(back) < DEPTH) begin
        r.status = win_valid[back[3:0]] ? STAT_REPLACED : STAT_FILLED;
        win_valid[back[3:0]] = 1'b1;
        win_data[back[3:0]] = p.payload;
      end else begin
        r.status = STAT_DROPPED;
      end
      lim = (win_limit == 5'd0) ? 1 : (int'(win_limit) > DEPTH) ? DEPTH : int'(win_limit);
      if (win_len > lim) win_len = lim;
      for (int k = win_len; k < DEPTH; k++) begin
        win_valid[k] = 1'b0;
        win_data[k] = '0;
      end
    end
    r.head = win_head;
    r.occ = win_len[4:0];
    return r;
  endfunction

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      win_valid[k] = 1'b0;
      win_data[k] = '0;
    end
  end

  always @(posedge clk) begin
    packet_t p;
    if (s_tvalid && s_tready) begin
      p.op = s_tuser[0];
      p.seq = s_tdata[15:0];
      p.payload = s_tdata[47:16];
      p.offset = s_tdata[51:48];
      expected_results.insert(expected_results.size(), jitter_step(p));
      sent_at_edge = 1'b1;
    end
  end

  always @(negedge clk) begin
    packet_t p;
    if (!rst && (!s_tvalid || sent_at_edge)) begin
      sent_at_edge = 1'b0;
      if (pending_packets.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        p = pending_packets.pop_front();
        s_tdata <= {4'b0, p.offset, p.payload, p.seq};
        s_tuser <= p.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    window_result_t e;
    if (m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transaction on the result side");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (m_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_tuser);
          error_count++;
        end
        if (m_tdata[15:0] !== e.head) begin
          $error("head_seq: expected %0h, got %0h", e.head, m_tdata[15:0]);
          error_count++;
        end
        if (m_tdata[20:16] !== e.occ) begin
          $error("occupancy: expected %0d, got %0d", e.occ, m_tdata[20:16]);
          error_count++;
        end
        if (m_tdata[21] !== e.full) begin
          $error("slot_full: expected %0d, got %0d", e.full, m_tdata[21]);
          error_count++;
        end
        if (m_tdata[53:22] !== e.payload) begin
          $error("slot_payload: expected %0h, got %0h", e.payload, m_tdata[53:22]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic add_packet(logic op, logic [15:0] seq, logic [31:0] payload,
                            logic [3:0] offset);
    packet_t p;
    p.op = op;
    p.seq = seq;
    p.payload = payload;
    p.offset = offset;
    pending_packets.insert(pending_packets.size(), p);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (!(pending_packets.size() == 0 && !s_tvalid && expected_results.size() == 0));
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_limit = value;
  endtask

  task automatic add_random_traffic(int count);
    int pick;
    logic [15:0] seq;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      seq = 16'($urandom);
      if (pick < 35) begin
        add_packet(OP_READ, seq, $urandom, 4'($urandom_range(0, 15)));
      end else begin
        if (pick < 60) begin
          seq = gen_head + 16'($urandom_range(1, 3));
        end else if (pick < 82) begin
          seq = gen_head - 16'($urandom_range(0, 17));
        end else if (pick < 88) begin
          seq = gen_head + 16'($urandom_range(4, 40));
        end else if (pick < 95) begin
          seq = gen_head + 16'h8000 + 16'($urandom_range(0, 2)) - 16'd1;
        end
        if ((seq - gen_head) >= 16'd1 && (seq - gen_head) <= 16'd32767) gen_head = seq;
        add_packet(OP_DELIVER, seq, $urandom, 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    logic [4:0] limits[6];
    limits = '{5'd1, 5'd31, 5'd0, 5'd5, 5'd16, 5'($urandom_range(2, 15))};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_packet(OP_READ,    16'h1234, 32'h0,        4'd0);
    add_packet(OP_READ,    16'hFFFF, 32'hFFFFFFFF, 4'd15);
    add_packet(OP_DELIVER, 16'hFFFF, 32'hFFFFFFFF, 4'd15);
    add_packet(OP_DELIVER, 16'h0001, 32'h00000000, 4'd0);
    add_packet(OP_DELIVER, 16'h0000, 32'hA5A5A5A5, 4'd0);
    add_packet(OP_DELIVER, 16'h0000, 32'h5A5A5A5A, 4'd0);
    for (int k = 0; k < 4; k++) add_packet(OP_READ, 16'h0, 32'h0, 4'(k));
    add_packet(OP_DELIVER, 16'h8000, 32'h80000001, 4'd0);
    add_packet(OP_DELIVER, 16'h0000, 32'h00000002, 4'd0);
    add_packet(OP_DELIVER, 16'h7FF1, 32'h00000003, 4'd0);
    add_packet(OP_DELIVER, 16'h800F, 32'h0000000F, 4'd0);
    add_packet(OP_DELIVER, 16'h8000, 32'hDEADBEEF, 4'd0);
    add_packet(OP_DELIVER, 16'h8010, 32'h00000010, 4'd0);
    add_packet(OP_DELIVER, 16'h8000, 32'h00000011, 4'd0);
    add_packet(OP_READ,    16'h0,    32'h0,        4'd15);
    add_packet(OP_READ,    16'h0,    32'h0,        4'd14);
    add_packet(OP_DELIVER, 16'h8020, 32'h00000020, 4'd0);
    add_packet(OP_READ,    16'h0,    32'h0,        4'd1);
    add_packet(OP_DELIVER, 16'h801F, 32'h0000001F, 4'd0);
    add_packet(OP_READ,    16'h0,    32'h0,        4'd1);
    wait_drained();
    gen_head = 16'h8020;

    for (int seg = 0; seg < 6; seg++) begin
      write_limit(limits[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      add_packet(OP_READ, 16'($urandom), $urandom, 4'd15);
      add_random_traffic(115);
      if (seg == 2) wait_drained();
      add_random_traffic(115);
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/sojb_pkg.sv
sv/sojb_ram.sv
sv/seq_ordered_jitter_buffer.sv
sim/tb.sv
